// ----- rtl/ddw_pkg.sv -----
package ddw_pkg;

    localparam int DEF_NUMBER_WIDTH = 32;
    localparam int MAX_WRITES       = 10;
    localparam int START_W          = 4;
    localparam int PAD_W            = 4;
    localparam int ADDR_W           = 5;
    localparam int DIGIT_W          = 4;

    // Decimal digits needed to hold any value of the given bit width.
    function automatic int digits_for_width(input int width);
        return (width * 30103) / 100000 + 1;
    endfunction

endpackage

// ----- rtl/ddw_front.sv -----
module ddw_front
    import ddw_pkg::*;
#(
    parameter int NUMBER_WIDTH = DEF_NUMBER_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [START_W-1:0]             i_start_position,
    input  logic [NUMBER_WIDTH-1:0]        i_number,
    input  logic [PAD_W-1:0]               i_min_digits,
    output logic                           o_push,
    input  logic                           i_push_ready,
    output logic [START_W-1:0]             o_start,
    output logic [digits_for_width(NUMBER_WIDTH)*DIGIT_W-1:0] o_digits,
    output logic [PAD_W-1:0]               o_pad
);

    localparam int NDIG   = digits_for_width(NUMBER_WIDTH);
    localparam int BCD_W  = NDIG * DIGIT_W;
    localparam int PADW   = ((NUMBER_WIDTH + 3) / 4) * 4;
    localparam int STEPS  = PADW / 4;
    localparam int CNT_W  = $clog2(STEPS + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CONV = 3'b010,
        S_PUSH = 3'b100
    } t_state;

    t_state             r_state, n_state;
    logic [PADW-1:0]    r_shift, n_shift;
    logic [BCD_W-1:0]   r_bcd, n_bcd;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [START_W-1:0] r_start, n_start;
    logic [PAD_W-1:0]   r_pad, n_pad;

    logic               accept;
    logic [PADW-1:0]    step_shift;
    logic [BCD_W-1:0]   step_bcd;

    assign o_ready  = (r_state == S_IDLE) || ((r_state == S_PUSH) && i_push_ready);
    assign accept   = i_valid && o_ready;
    assign o_push   = (r_state == S_PUSH);
    assign o_start  = r_start;
    assign o_digits = r_bcd;
    assign o_pad    = r_pad;

    // Four shift-and-adjust steps of binary to BCD conversion per cycle.
    always_comb begin
        logic [BCD_W-1:0] b;
        logic [PADW-1:0]  s;
        b = r_bcd;
        s = r_shift;
        for (int st = 0; st < 4; st++) begin
            for (int d = 0; d < NDIG; d++) begin
                if (b[d*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
                    b[d*DIGIT_W +: DIGIT_W] = b[d*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
                end
            end
            b = {b[BCD_W-2:0], s[PADW-1]};
            s = {s[PADW-2:0], 1'b0};
        end
        step_bcd   = b;
        step_shift = s;
    end

    always_comb begin
        n_state = r_state;
        n_shift = r_shift;
        n_bcd   = r_bcd;
        n_cnt   = r_cnt;
        n_start = r_start;
        n_pad   = r_pad;
        case (r_state)
            S_CONV: begin
                n_shift = step_shift;
                n_bcd   = step_bcd;
                n_cnt   = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    n_shift = r_shift;
                    n_bcd   = r_bcd;
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (i_push_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (accept) begin
            n_shift = PADW'(i_number);
            n_bcd   = '0;
            n_cnt   = CNT_W'(STEPS);
            n_start = i_start_position;
            n_pad   = (i_min_digits > PAD_W'(MAX_WRITES)) ? PAD_W'(MAX_WRITES) : i_min_digits;
            // drop items that cause no write
            if ((i_number == '0) && (i_min_digits == '0)) begin
                n_state = S_IDLE;
            end else begin
                n_state = S_CONV;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_shift <= n_shift;
        r_bcd   <= n_bcd;
        r_cnt   <= n_cnt;
        r_start <= n_start;
        r_pad   <= n_pad;
    end

endmodule

// ----- rtl/ddw_queue.sv -----
module ddw_queue
    import ddw_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_push_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wptr, r_rptr;
    logic [1:0]       r_count;
    logic             do_push, do_pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_valid      = (r_count != 2'd0);
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_valid;
    assign o_data       = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) begin
                r_wptr <= ~r_wptr;
            end
            if (do_pop) begin
                r_rptr <= ~r_rptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 2'd1;
            end
        end
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

// ----- rtl/ddw_back.sv -----
module ddw_back
    import ddw_pkg::*;
#(
    parameter int NUMBER_WIDTH = DEF_NUMBER_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_entry_valid,
    output logic                           o_entry_pop,
    input  logic [START_W-1:0]             i_start,
    input  logic [digits_for_width(NUMBER_WIDTH)*DIGIT_W-1:0] i_digits,
    input  logic [PAD_W-1:0]               i_pad,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [ADDR_W-1:0]              o_digit_address,
    output logic [DIGIT_W-1:0]             o_digit_value,
    output logic                           o_last
);

    localparam int NDIG  = digits_for_width(NUMBER_WIDTH);
    localparam int BCD_W = NDIG * DIGIT_W;

    logic               r_active;
    logic [BCD_W-1:0]   r_digits;
    logic [PAD_W-1:0]   r_k;
    logic [PAD_W-1:0]   r_pad;
    logic [START_W-1:0] r_start;
    logic               r_valid;
    logic [ADDR_W-1:0]  r_addr;
    logic [DIGIT_W-1:0] r_value;
    logic               r_last;

    logic               can_load;
    logic               last_now;
    logic [PAD_W:0]     k_next;

    assign can_load    = !r_valid || i_ready;
    assign o_entry_pop = !r_active;
    assign k_next      = {1'b0, r_k} + (PAD_W + 1)'(1);
    assign last_now    = (r_k == PAD_W'(MAX_WRITES - 1))
                      || ((r_digits[BCD_W-1:DIGIT_W] == '0) && (k_next >= {1'b0, r_pad}));

    assign o_valid         = r_valid;
    assign o_digit_address = r_addr;
    assign o_digit_value   = r_value;
    assign o_last          = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            if (can_load) begin
                r_valid <= r_active;
            end
            if (!r_active) begin
                r_active <= i_entry_valid;
            end else if (can_load && last_now) begin
                r_active <= 1'b0;
            end
        end
        if (!r_active) begin
            r_digits <= i_digits;
            r_pad    <= i_pad;
            r_start  <= i_start;
            r_k      <= '0;
        end else if (can_load) begin
            r_digits <= r_digits >> DIGIT_W;
            r_k      <= k_next[PAD_W-1:0];
        end
        if (r_active && can_load) begin
            r_addr  <= ADDR_W'(r_start) + ADDR_W'(r_k);
            r_value <= r_digits[DIGIT_W-1:0];
            r_last  <= last_now;
        end
    end

endmodule

// ----- rtl/decimal_digit_display_writer.sv -----
// Decimal digit display writer.
// Input channel (i_valid/o_ready) takes one item: a start digit address, an
// unsigned number and a minimum digit count. Output channel (o_valid/i_ready)
// gives one digit-register write per result digit, least significant digit
// first, addresses rising from the start; o_last marks the final write.
// An item with a zero number and a zero count gives no write and is dropped.
// Front: binary to BCD conversion, four bits per cycle, then a final S_CONV
// state with the count at zero and S_PUSH, which hands the entry on.
// A two-entry queue sits between front and back.
// Back: one digit write per cycle while the receiver is ready; when an entry
// is done the back goes idle and loads the next one from the queue.
// The front takes a new item as it pushes the last, so conversion overlaps
// the back's writes; the slower of the two sets the item rate.
// Reset (synchronous, active low) empties the queue and drops work in flight.
// When the receiver stalls, the current write holds on the outputs, the back
// stops, the queue fills, and then the front stops taking items.
module decimal_digit_display_writer
    import ddw_pkg::*;
#(
    parameter int NUMBER_WIDTH = DEF_NUMBER_WIDTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [START_W-1:0]      i_start_position,
    input  logic [NUMBER_WIDTH-1:0] i_number,
    input  logic [PAD_W-1:0]        i_min_digits,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [ADDR_W-1:0]       o_digit_address,
    output logic [DIGIT_W-1:0]      o_digit_value,
    output logic                    o_last
);

    localparam int BCD_W   = digits_for_width(NUMBER_WIDTH) * DIGIT_W;
    localparam int ENTRY_W = START_W + BCD_W + PAD_W;

    logic               push, push_ready;
    logic [START_W-1:0] f_start, b_start;
    logic [BCD_W-1:0]   f_digits, b_digits;
    logic [PAD_W-1:0]   f_pad, b_pad;
    logic               entry_valid, entry_pop;
    logic [ENTRY_W-1:0] q_out;

    ddw_front #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_start_position (i_start_position),
        .i_number         (i_number),
        .i_min_digits     (i_min_digits),
        .o_push           (push),
        .i_push_ready     (push_ready),
        .o_start          (f_start),
        .o_digits         (f_digits),
        .o_pad            (f_pad)
    );

    ddw_queue #(.WIDTH(ENTRY_W)) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_push_ready (push_ready),
        .i_data       ({f_start, f_digits, f_pad}),
        .o_valid      (entry_valid),
        .i_pop        (entry_pop),
        .o_data       (q_out)
    );

    assign {b_start, b_digits, b_pad} = q_out;

    ddw_back #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_entry_valid   (entry_valid),
        .o_entry_pop     (entry_pop),
        .i_start         (b_start),
        .i_digits        (b_digits),
        .i_pad           (b_pad),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_digit_address (o_digit_address),
        .o_digit_value   (o_digit_value),
        .o_last          (o_last)
    );

endmodule
